// File: design/cfpr_pkg.sv
// shared types, constants and the crc-8 step for the framed packet receiver
// no dependencies; used by every module of the block
`default_nettype none

package cfpr_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_W       = 2;

    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] END_MARKER_RST   = 8'h55;
    localparam logic [7:0] CRC_POLY         = 8'h07;
    localparam logic [7:0] CRC_INIT         = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_ID      = 3'd1,
        PH_LEN     = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4,
        PH_END     = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_FETCH = 2'd1,
        B_SHOW  = 2'd2
    } back_state_t;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_CRC_BAD = 2'd1,
        ST_END_BAD = 2'd2,
        ST_LEN_BAD = 2'd3
    } frame_status_t;

    typedef struct packed {
        frame_status_t status;
        logic [7:0]    id;
        logic [7:0]    len;
    } entry_t;

    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } store_wr_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/crc8_framed_packet_receiver.sv
// framed packet receiver with crc-8 check: top level, marker registers, wiring
// depends on cfpr_pkg, cfpr_front, cfpr_queue, cfpr_back
//
// usage: one received byte per input beat on s_tvalid/s_tready/s_tdata. frames
// are start marker, id, length, payload, check byte, end marker; the crc-8
// (poly 0x07, init 0) covers id, length and payload. a good frame gives one
// result beat per payload byte, tlast on the final one; a zero-length frame
// gives one beat. a bad length, bad end byte or crc mismatch gives one status
// beat. bytes outside a frame give nothing.
// input: the parser takes a byte every cycle while the verdict queue is not
// full; payload bytes also wait until the sequencer is idle and the queue is
// empty, so the store is never overwritten while an earlier frame is still read out.
// output: a verdict goes through a two-entry queue; the sequencer pops it and,
// for a payload frame, reads the first byte from the store before the beat is
// shown; a status or zero-length beat needs no read, and each further payload
// beat follows one more store read after the previous one is taken.
// a stalled receiver holds the beat steady; the parser keeps taking non-payload
// bytes until the queue is full. reset clears the parser, queue and sequencer and
// sets the markers to 0xaa and 0x55; the payload store needs no clearing.
// config: cfg_we writes cfg_data to register cfg_addr (0 start, 1 end marker)
`default_nettype none

module crc8_framed_packet_receiver #(
    parameter int MAX_PAYLOAD = cfpr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // frame_status[1:0], message_id[9:2], payload_length[17:10],
    // byte_index[23:18], payload_byte[31:24]
    output logic [31:0]                        m_tdata,
    output logic                               m_tlast,   // last_of_run
    input  wire logic                          cfg_we,
    input  wire logic [cfpr_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [7:0]                    cfg_data
);

    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;

    logic                   q_push;
    cfpr_pkg::entry_t       q_in;
    logic                   q_pop;
    logic                   q_valid;
    logic                   q_full;
    cfpr_pkg::entry_t       q_out;
    cfpr_pkg::store_wr_t    store_wr;
    cfpr_pkg::back_status_t back_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= cfpr_pkg::START_MARKER_RST;
            end_marker_reg   <= cfpr_pkg::END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == cfpr_pkg::REG_START_MARKER)
            begin
                start_marker_reg <= cfg_data;
            end
            else if (cfg_addr == cfpr_pkg::REG_END_MARKER)
            begin
                end_marker_reg <= cfg_data;
            end
        end
    end

    cfpr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .q_full       (q_full),
        .q_valid      (q_valid),
        .back_status  (back_status),
        .q_push       (q_push),
        .q_data       (q_in),
        .store_wr     (store_wr)
    );

    cfpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .valid     (q_valid),
        .full      (q_full),
        .data      (q_out)
    );

    cfpr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .store_wr    (store_wr),
        .q_valid     (q_valid),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .back_status (back_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire

// File: design/cfpr_front.sv
// front part: frame parser, running crc-8, payload store writes, frame verdicts
// depends on cfpr_pkg
`default_nettype none

module cfpr_front #(
    parameter int MAX_PAYLOAD = cfpr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire logic [7:0]           start_marker,
    input  wire logic [7:0]           end_marker,
    input  wire logic                 q_full,
    input  wire logic                 q_valid,
    input  wire cfpr_pkg::back_status_t back_status,
    output logic                      q_push,
    output cfpr_pkg::entry_t          q_data,
    output cfpr_pkg::store_wr_t       store_wr
);

    localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

    cfpr_pkg::phase_t phase_reg, phase_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] fill_reg, fill_next;
    logic [7:0] rcheck_reg, rcheck_next;
    logic [7:0] crc_reg, crc_next;

    logic       beat;
    logic [7:0] crc_step;
    logic [7:0] fill_inc;
    logic       len_over;

    assign beat     = s_tvalid && s_tready;
    assign crc_step = cfpr_pkg::crc8_update(crc_reg, s_tdata);
    assign fill_inc = 8'(fill_reg + 8'd1);
    assign len_over = {1'b0, s_tdata} > MAX_LEN;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (beat)
        begin
            unique case (phase_reg)
                cfpr_pkg::PH_START:
                begin
                    if (s_tdata == start_marker)
                    begin
                        phase_next = cfpr_pkg::PH_ID;
                    end
                end
                cfpr_pkg::PH_ID:      phase_next = cfpr_pkg::PH_LEN;
                cfpr_pkg::PH_LEN:
                begin
                    if (len_over)
                    begin
                        phase_next = cfpr_pkg::PH_START;
                    end
                    else if (s_tdata == 8'd0)
                    begin
                        phase_next = cfpr_pkg::PH_CHECK;
                    end
                    else
                    begin
                        phase_next = cfpr_pkg::PH_PAYLOAD;
                    end
                end
                cfpr_pkg::PH_PAYLOAD:
                begin
                    if (fill_inc >= len_reg)
                    begin
                        phase_next = cfpr_pkg::PH_CHECK;
                    end
                end
                cfpr_pkg::PH_CHECK:   phase_next = cfpr_pkg::PH_END;
                cfpr_pkg::PH_END:     phase_next = cfpr_pkg::PH_START;
                default:              phase_next = cfpr_pkg::PH_START;
            endcase
        end
    end

    // held fields and crc
    always_comb
    begin
        id_next     = id_reg;
        len_next    = len_reg;
        fill_next   = fill_reg;
        rcheck_next = rcheck_reg;
        crc_next    = crc_reg;
        if (beat)
        begin
            unique case (phase_reg)
                cfpr_pkg::PH_START:
                begin
                    if (s_tdata == start_marker)
                    begin
                        crc_next = cfpr_pkg::CRC_INIT;
                    end
                end
                cfpr_pkg::PH_ID:
                begin
                    id_next  = s_tdata;
                    crc_next = crc_step;
                end
                cfpr_pkg::PH_LEN:
                begin
                    if (!len_over)
                    begin
                        len_next  = s_tdata;
                        crc_next  = crc_step;
                        fill_next = 8'd0;
                    end
                end
                cfpr_pkg::PH_PAYLOAD:
                begin
                    crc_next  = crc_step;
                    fill_next = fill_inc;
                end
                cfpr_pkg::PH_CHECK:   rcheck_next = s_tdata;
                cfpr_pkg::PH_END:     ;
                default:              ;
            endcase
        end
    end

    // handshake, verdict push and store write
    always_comb
    begin
        s_tready = !q_full &&
                   !(phase_reg == cfpr_pkg::PH_PAYLOAD && (back_status.busy || q_valid));
        q_push        = 1'b0;
        q_data.status = cfpr_pkg::ST_GOOD;
        q_data.id     = id_reg;
        q_data.len    = len_reg;
        store_wr.en   = 1'b0;
        store_wr.addr = fill_reg;
        store_wr.data = s_tdata;
        if (beat)
        begin
            unique case (phase_reg)
                cfpr_pkg::PH_LEN:
                begin
                    if (len_over)
                    begin
                        q_push        = 1'b1;
                        q_data.status = cfpr_pkg::ST_LEN_BAD;
                        q_data.len    = s_tdata;
                    end
                end
                cfpr_pkg::PH_PAYLOAD: store_wr.en = 1'b1;
                cfpr_pkg::PH_END:
                begin
                    q_push = 1'b1;
                    if (s_tdata != end_marker)
                    begin
                        q_data.status = cfpr_pkg::ST_END_BAD;
                    end
                    else if (rcheck_reg != crc_reg)
                    begin
                        q_data.status = cfpr_pkg::ST_CRC_BAD;
                    end
                end
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cfpr_pkg::PH_START;
            id_reg     <= 8'd0;
            len_reg    <= 8'd0;
            fill_reg   <= 8'd0;
            rcheck_reg <= 8'd0;
            crc_reg    <= cfpr_pkg::CRC_INIT;
        end
        else
        begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            len_reg    <= len_next;
            fill_reg   <= fill_next;
            rcheck_reg <= rcheck_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cfpr_queue.sv
// short queue of frame verdicts between the parser and the result sequencer
// depends on cfpr_pkg
`default_nettype none

module cfpr_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire cfpr_pkg::entry_t push_data,
    input  wire logic             pop,
    output logic                  valid,
    output logic                  full,
    output cfpr_pkg::entry_t      data
);

    localparam int DEPTH = cfpr_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    cfpr_pkg::entry_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign valid = count_reg != CW'(0);
    assign full  = count_reg == CW'(DEPTH);
    assign data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : PW'(wr_ptr_reg + PW'(1));
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : PW'(rd_ptr_reg + PW'(1));
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + CW'(1));
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cfpr_back.sv
// back part: payload store and result sequencer that plays out verdicts as beats
// depends on cfpr_pkg
`default_nettype none

module cfpr_back #(
    parameter int MAX_PAYLOAD = cfpr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfpr_pkg::store_wr_t store_wr,
    input  wire logic                q_valid,
    input  wire cfpr_pkg::entry_t    q_data,
    output logic                     q_pop,
    output cfpr_pkg::back_status_t   back_status,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [31:0]              m_tdata,
    output logic                     m_tlast
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0] store_mem [MAX_PAYLOAD];

    cfpr_pkg::back_state_t state_reg, state_next;
    cfpr_pkg::entry_t      ent_reg, ent_next;
    logic [7:0]            idx_reg, idx_next;
    logic                  run_reg, run_next;
    logic [7:0]            byte_reg;

    logic [7:0] idx_inc;
    logic       is_last;
    logic       beat;

    assign idx_inc = 8'(idx_reg + 8'd1);
    assign is_last = !run_reg || (idx_inc == ent_reg.len);
    assign beat    = m_tvalid && m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfpr_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.status == cfpr_pkg::ST_GOOD && q_data.len != 8'd0)
                    begin
                        state_next = cfpr_pkg::B_FETCH;
                    end
                    else
                    begin
                        state_next = cfpr_pkg::B_SHOW;
                    end
                end
            end
            cfpr_pkg::B_FETCH: state_next = cfpr_pkg::B_SHOW;
            cfpr_pkg::B_SHOW:
            begin
                if (beat)
                begin
                    state_next = is_last ? cfpr_pkg::B_IDLE : cfpr_pkg::B_FETCH;
                end
            end
            default:           state_next = cfpr_pkg::B_IDLE;
        endcase
    end

    // held verdict and run position
    always_comb
    begin
        ent_next = ent_reg;
        idx_next = idx_reg;
        run_next = run_reg;
        if (state_reg == cfpr_pkg::B_IDLE && q_valid)
        begin
            ent_next = q_data;
            idx_next = 8'd0;
            run_next = (q_data.status == cfpr_pkg::ST_GOOD) && (q_data.len != 8'd0);
        end
        else if (state_reg == cfpr_pkg::B_SHOW && beat && !is_last)
        begin
            idx_next = idx_inc;
        end
    end

    // outputs
    always_comb
    begin
        q_pop            = (state_reg == cfpr_pkg::B_IDLE) && q_valid;
        back_status.busy = state_reg != cfpr_pkg::B_IDLE;
        m_tvalid         = state_reg == cfpr_pkg::B_SHOW;
        m_tlast          = is_last;
        m_tdata          = {(run_reg ? byte_reg : 8'd0), idx_reg[5:0], ent_reg.len,
                            ent_reg.id, ent_reg.status};
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            store_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
        end
        if (state_reg == cfpr_pkg::B_FETCH)
        begin
            byte_reg <= store_mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfpr_pkg::B_IDLE;
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
        end
    end

endmodule

`default_nettype wire
